// ===== rtl/ntpc_pkg.sv =====
// Nearest trapezoid point clamp: shared types, constants and the box record.
// No dependencies.
package ntpc_pkg;

    localparam int MAX_BOXES_DEFAULT = 32;
    localparam int COORD_W = 8;
    localparam int COST_W = 9;
    localparam int CNT_W = 6;
    localparam int BIS_STEPS = 8;

    typedef struct packed {
        logic                 invisible;
        logic [COORD_W-1:0]   brx;
        logic [COORD_W-1:0]   blx;
        logic [COORD_W-1:0]   trx;
        logic [COORD_W-1:0]   tlx;
        logic [COORD_W-1:0]   by;
        logic [COORD_W-1:0]   ty;
    } box_t;

    localparam int BOX_W = $bits(box_t);

    // Query request passed from front to back.
    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [CNT_W-1:0]   n;
    } query_t;

endpackage

// ===== rtl/ntpc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module ntpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== rtl/ntpc_front.sv =====
// Front end: accepts items, writes boxes into the table, queues queries.
// Depends on ntpc_pkg; writes the table RAM, which lives in the top level.
module ntpc_front #(
    parameter int MAX_BOXES = ntpc_pkg::MAX_BOXES_DEFAULT,
    parameter int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  mode,
    input  logic [4:0]            box_index,
    input  ntpc_pkg::box_t        box_in,
    input  logic [7:0]            point_x,
    input  logic [7:0]            point_y,
    input  logic [5:0]            num_boxes,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output ntpc_pkg::box_t        wr_data,
    output logic                  q_valid,
    input  logic                  q_ready,
    output ntpc_pkg::query_t      q_data
);
    import ntpc_pkg::*;

    // Two-entry queue of queries.
    query_t      fifo_reg [2];
    logic        wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;
    logic [CNT_W-1:0] n_clip;

    // hold a box write until no query is queued or being scanned
    assign s_ready = (cnt_reg != 2'd2) && (mode || (cnt_reg == 2'd0 && q_ready));
    assign push = s_valid && s_ready && mode;
    assign pop  = q_valid && q_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = fifo_reg[rp_reg];

    assign n_clip = ({26'd0, num_boxes} > MAX_BOXES) ? CNT_W'(MAX_BOXES) : num_boxes;

    assign wr_en = s_valid && s_ready && !mode && ({27'd0, box_index} < MAX_BOXES);
    assign wr_addr = AW'(box_index);
    assign wr_data = box_in;

    always_comb begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            fifo_reg[wp_reg] <= '{px: point_x, py: point_y, n: n_clip};
        end
    end
endmodule

// ===== rtl/ntpc_back.sv =====
// Back end: scans boxes from the top index down, clamps the point into each
// visible box and keeps the best. Depends on ntpc_pkg; reads the table RAM port.
module ntpc_back #(
    parameter int MAX_BOXES = ntpc_pkg::MAX_BOXES_DEFAULT,
    parameter int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  ntpc_pkg::query_t      q_data,
    output logic [AW-1:0]         rd_addr,
    input  ntpc_pkg::box_t        rd_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [30:0]           m_data
);
    import ntpc_pkg::*;

    typedef enum logic [2:0] {IDLE, READ, CLASS, BISECT, COST, NEXT, DONE} state_t;

    state_t state_reg;
    query_t q_reg;
    logic [CNT_W-1:0] k_reg;          // next index + 1
    logic [AW-1:0] cur_reg;
    logic [8:0] xa_reg, xb_reg, ya_reg, yb_reg, xm_reg, ym_reg;
    logic [3:0] step_reg;
    logic left_reg;                   // bisection is for the low bound
    logic [7:0] lo_reg, hi_reg, yc_reg;
    logic found_reg;
    logic [15:0] best_reg;
    logic [7:0] bx_reg, by_reg;
    logic [4:0] bi_reg;
    logic out_valid_reg;
    logic [30:0] out_reg;

    logic [8:0] xmid, ymid;
    logic [7:0] xc, dxv, dyf, dy2;
    logic [8:0] cval;

    assign q_ready = (state_reg == IDLE);
    assign rd_addr = AW'(k_reg - 1'b1);
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    assign xmid = (xa_reg + xb_reg) >> 1;
    assign ymid = (ya_reg + yb_reg) >> 1;

    always_comb begin
        if (q_reg.px < lo_reg) xc = lo_reg;
        else if (q_reg.px > hi_reg) xc = hi_reg;
        else xc = q_reg.px;
        dxv = (xc > q_reg.px) ? xc - q_reg.px : q_reg.px - xc;
        dyf = (yc_reg > q_reg.py) ? yc_reg - q_reg.py : q_reg.py - yc_reg;
        dy2 = dyf >> 2;
        if (dxv < dy2) cval = 9'(dxv >> 1) + 9'(dy2);
        else cval = 9'(dxv) + 9'(dy2 >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            // DONE drives the output valid itself
            if (out_valid_reg && m_ready && state_reg != DONE) out_valid_reg <= 1'b0;
            case (state_reg)
                IDLE: begin
                    if (q_valid) begin
                        q_reg <= q_data;
                        k_reg <= q_data.n;
                        found_reg <= 1'b0;
                        best_reg <= 16'hffff;
                        bx_reg <= q_data.px;
                        by_reg <= q_data.py;
                        bi_reg <= 5'd0;
                        state_reg <= (q_data.n == '0) ? DONE : READ;
                    end
                end
                READ: begin
                    cur_reg <= AW'(k_reg - 1'b1);
                    state_reg <= CLASS;
                end
                CLASS: begin
                    step_reg <= 4'd0;
                    if (rd_data.invisible) begin
                        state_reg <= NEXT;
                    end else if (q_reg.py >= rd_data.by) begin
                        yc_reg <= rd_data.by; lo_reg <= rd_data.blx; hi_reg <= rd_data.brx;
                        state_reg <= COST;
                    end else if (q_reg.py < rd_data.ty) begin
                        yc_reg <= rd_data.ty; lo_reg <= rd_data.tlx; hi_reg <= rd_data.trx;
                        state_reg <= COST;
                    end else begin
                        yc_reg <= q_reg.py;
                        ya_reg <= {1'b0, rd_data.ty}; yb_reg <= {1'b0, rd_data.by};
                        ym_reg <= {1'b0, rd_data.ty};
                        if (q_reg.px < rd_data.tlx || q_reg.px < rd_data.blx) begin
                            left_reg <= 1'b1;
                            xa_reg <= {1'b0, rd_data.tlx}; xb_reg <= {1'b0, rd_data.blx};
                            xm_reg <= {1'b0, rd_data.tlx};
                            state_reg <= BISECT;
                        end else if (q_reg.px > rd_data.trx || q_reg.px > rd_data.brx) begin
                            left_reg <= 1'b0;
                            xa_reg <= {1'b0, rd_data.trx}; xb_reg <= {1'b0, rd_data.brx};
                            xm_reg <= {1'b0, rd_data.trx};
                            state_reg <= BISECT;
                        end else begin
                            lo_reg <= (rd_data.tlx > rd_data.blx) ? rd_data.tlx : rd_data.blx;
                            hi_reg <= (rd_data.trx < rd_data.brx) ? rd_data.trx : rd_data.brx;
                            state_reg <= COST;
                        end
                    end
                end
                BISECT: begin
                    // one midpoint step a cycle; stop on match or after eight
                    if (step_reg == 4'(BIS_STEPS) || ym_reg == {1'b0, q_reg.py}) begin
                        if (left_reg) begin
                            lo_reg <= xm_reg[7:0]; hi_reg <= q_reg.px;
                        end else begin
                            lo_reg <= q_reg.px; hi_reg <= xm_reg[7:0];
                        end
                        state_reg <= COST;
                    end else begin
                        xm_reg <= xmid;
                        ym_reg <= ymid;
                        if (ymid > {1'b0, q_reg.py}) begin
                            yb_reg <= ymid; xb_reg <= xmid;
                        end else begin
                            ya_reg <= ymid; xa_reg <= xmid;
                        end
                        step_reg <= step_reg + 4'd1;
                    end
                end
                COST: begin
                    found_reg <= 1'b1;
                    if (cval == 9'd0) begin
                        best_reg <= 16'd0; bx_reg <= xc; by_reg <= yc_reg;
                        bi_reg <= 5'(cur_reg);
                        state_reg <= DONE;
                    end else begin
                        if ({7'd0, cval} <= best_reg) begin
                            best_reg <= {7'd0, cval}; bx_reg <= xc; by_reg <= yc_reg;
                            bi_reg <= 5'(cur_reg);
                        end
                        state_reg <= NEXT;
                    end
                end
                NEXT: begin
                    k_reg <= k_reg - 1'b1;
                    state_reg <= (k_reg == CNT_W'(1)) ? DONE : READ;
                end
                DONE: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg <= 1'b1;
                        out_reg <= {(found_reg ? best_reg[8:0] : 9'd0), by_reg, bx_reg,
                                    bi_reg, found_reg};
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/nearest_trapezoid_point_clamp_top.sv =====
// Nearest trapezoid point clamp, top level.
// Depends on ntpc_pkg, ntpc_ram, ntpc_front and ntpc_back.
//
// Write items (tuser 0) store a box in the table and return nothing. A query
// (tuser 1) scans the boxes in use from the highest index down, one box at a
// time through the table RAM's single read port: each box is read and
// classified, a visible box is then costed, and a box inside the slanted band
// adds bisection steps first; an early stop on a box holding the point. A
// two-entry queue lets queries be accepted while a query runs; a write waits
// until no query is queued or being scanned, so every query sees the table as
// it stood when the query was accepted.
module nearest_trapezoid_point_clamp_top #(
    parameter int MAX_BOXES = ntpc_pkg::MAX_BOXES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // box_index[4:0], top_y, bot_y, top_left_x, top_right_x, bottom_left_x,
    // bottom_right_x, box_invisible, point_x, point_y, zero pad [71:70]
    input  logic [71:0] s_tdata,
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    // found, chosen_box[5:1], corrected_x, corrected_y, cost[30:22], pad
    output logic [31:0] m_tdata
);
    import ntpc_pkg::*;

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    logic [CNT_W-1:0] num_boxes_reg;
    box_t box_in, rd_data, wr_data;
    logic wr_en, q_valid, q_ready;
    logic [AW-1:0] wr_addr, rd_addr;
    query_t q_data;
    logic [30:0] m_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) num_boxes_reg <= '0;
        else if (cfg_wr_en) num_boxes_reg <= cfg_wr_data;
    end

    assign box_in = '{invisible: s_tdata[53], brx: s_tdata[52:45], blx: s_tdata[44:37],
                      trx: s_tdata[36:29], tlx: s_tdata[28:21], by: s_tdata[20:13],
                      ty: s_tdata[12:5]};

    ntpc_front #(.MAX_BOXES(MAX_BOXES), .AW(AW)) u_front (
        .aclk, .aresetn, .s_valid(s_tvalid), .s_ready(s_tready), .mode(s_tuser),
        .box_index(s_tdata[4:0]), .box_in, .point_x(s_tdata[61:54]),
        .point_y(s_tdata[69:62]), .num_boxes(num_boxes_reg), .wr_en, .wr_addr,
        .wr_data, .q_valid, .q_ready, .q_data
    );

    ntpc_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_table (
        .aclk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
    );

    ntpc_back #(.MAX_BOXES(MAX_BOXES), .AW(AW)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data, .rd_addr, .rd_data,
        .m_valid(m_tvalid), .m_ready(m_tready), .m_data
    );

    assign m_tdata = {1'b0, m_data};
endmodule
